// ----- hdl/iedr_pkg.sv -----
package iedr_pkg;

   // Width of one snapshot beat and of a reported port number.
   localparam int unsigned WORD_BITS = 64;
   localparam int unsigned PORT_W    = 7;

   typedef logic [PORT_W-1:0] port_num_type;

   // What one direction's picker hands back to the top level.
   typedef struct packed {
      logic         found;
      port_num_type port_num;
   } pick_type;

endpackage

// ----- hdl/iedr_picker.sv -----
module iedr_picker #(
   parameter int unsigned NUM_PORTS = 64
) (
   input  logic [NUM_PORTS-1:0] active,
   input  logic [NUM_PORTS-1:0] reported,
   output iedr_pkg::pick_type   pick,
   output logic [NUM_PORTS-1:0] reported_in
);
   import iedr_pkg::*;

   logic [NUM_PORTS-1:0] fresh;
   logic [NUM_PORTS-1:0] lowest;
   port_num_type         num;

   // Isolate the lowest fresh bit, then encode the one-hot result.
   assign fresh  = active & ~reported;
   assign lowest = fresh & (~fresh + NUM_PORTS'(1));

   always_comb begin
      num = '0;
      for (int i = 0; i < NUM_PORTS; i++) begin
         if (lowest[i]) begin
            num = num | PORT_W'(i + 1);
         end
      end
   end

   assign pick.found    = |fresh;
   assign pick.port_num = num;

   // Mark the picked port, then drop ports that have gone inactive.
   assign reported_in = (reported | lowest) & active;

endmodule

// ----- hdl/input_edge_event_reporter.sv -----
// Input edge event reporter. Each request beat carries one snapshot of up to
// 64 active-low input lines (bit n is port n+1, a 0 means pressed). For each
// direction the block keeps a mask of ports already reported; per snapshot it
// reports the lowest-numbered port that is newly pressed and the lowest that
// is newly released, as numbers 1..NUM_PORTS with 0 meaning none, and one
// response beat comes out for every request beat, in order. A port that stays
// active is reported once only, and becomes eligible again after it has gone
// inactive. Snapshot bits at and above NUM_PORTS are ignored. The block takes
// one beat per clock cycle while req_stall is low: a request is held in an
// input register, the priority encode and mask update run from there, and the
// result lands in an output register, where it is held while the response side
// stalls. req_stall rises only when both registers are full and the response
// side is stalling.
module input_edge_event_reporter #(
   parameter int unsigned NUM_PORTS = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [iedr_pkg::WORD_BITS-1:0]  req_raw_inputs,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [iedr_pkg::PORT_W-1:0]     rsp_press_port,
   output logic [iedr_pkg::PORT_W-1:0]     rsp_release_port
);
   import iedr_pkg::*;

   // Input register: the accepted snapshot, only the ports in use.
   logic                 s1_valid_ff, s1_valid_in;
   logic [NUM_PORTS-1:0] raw_ff, raw_in;

   // Reported masks, one per direction.
   logic [NUM_PORTS-1:0] press_rep_ff, press_rep_in;
   logic [NUM_PORTS-1:0] rel_rep_ff, rel_rep_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   port_num_type         press_ff, press_in;
   port_num_type         rel_ff, rel_in;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;
   pick_type             press_pick;
   pick_type             rel_pick;
   logic [NUM_PORTS-1:0] press_next;
   logic [NUM_PORTS-1:0] rel_next;

   // The output register can take a new result when it is empty or its
   // current beat is leaving this cycle.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Pressed is a low line, released a high one.
   iedr_picker #(.NUM_PORTS(NUM_PORTS)) u_press (
      .active      (~raw_ff),
      .reported    (press_rep_ff),
      .pick        (press_pick),
      .reported_in (press_next)
   );

   iedr_picker #(.NUM_PORTS(NUM_PORTS)) u_release (
      .active      (raw_ff),
      .reported    (rel_rep_ff),
      .pick        (rel_pick),
      .reported_in (rel_next)
   );

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      raw_in       = raw_ff;
      press_rep_in = press_rep_ff;
      rel_rep_in   = rel_rep_ff;
      rsp_valid_in = rsp_valid_ff;
      press_in     = press_ff;
      rel_in       = rel_ff;

      // The response beat leaves; a new one may replace it below.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // The held snapshot moves on: update the masks exactly once per beat.
      if (advance) begin
         s1_valid_in  = 1'b0;
         press_rep_in = press_next;
         rel_rep_in   = rel_next;
         rsp_valid_in = 1'b1;
         press_in     = press_pick.port_num;
         rel_in       = rel_pick.port_num;
      end

      if (req_take) begin
         s1_valid_in = 1'b1;
         raw_in      = req_raw_inputs[NUM_PORTS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         press_rep_ff <= '0;
         rel_rep_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         press_rep_ff <= press_rep_in;
         rel_rep_ff   <= rel_rep_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_ff   <= raw_in;
      press_ff <= press_in;
      rel_ff   <= rel_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_press_port   = press_ff;
   assign rsp_release_port = rel_ff;

   // A port cannot be reported as both pressed and released at once.
   a_masks_disjoint : assert property (@(posedge clock) disable iff (reset)
      (press_rep_ff & rel_rep_ff) == '0)
      else $error("press and release masks overlap");

   a_dirs_differ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && press_ff != '0 |-> press_ff != rel_ff)
      else $error("same port reported in both directions");

   a_num_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> press_ff <= PORT_W'(NUM_PORTS) && rel_ff <= PORT_W'(NUM_PORTS))
      else $error("reported port number out of range");

   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff)
      else $error("request stalled with room to spare");

   a_found_matches : assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && ((press_ff != '0) == $past(press_pick.found)))
      else $error("press result disagrees with picker");

endmodule

// ----- dv/input_edge_event_reporter_tb.sv -----
`timescale 1ns / 1ps

module input_edge_event_reporter_tb;

   import iedr_pkg::*;

   // The block is built for the full 64-line word. The prediction still
   // honours the port count, so the ignored high bits would be handled too.
   localparam int unsigned NUM_PORTS    = 64;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_BEATS = 650;
   localparam int          TAIL_CYCLES  = 8;

   // One response beat: the newly pressed and the newly released port
   // numbers, 0 meaning that there is nothing new in that direction.
   typedef struct packed {
      port_num_type press_port;
      port_num_type release_port;
   } edge_report_type;

   // Receiver behaviour. Each phase of the stall pattern runs for a random
   // number of cycles and then hands over to another one.
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_LONG
   } stall_mode_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [WORD_BITS-1:0]  req_raw_inputs   = '1;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [PORT_W-1:0]     rsp_press_port;
   logic [PORT_W-1:0]     rsp_release_port;

   // Snapshots still to be sent, and the reports that accepted snapshots
   // must produce, oldest first.
   logic [WORD_BITS-1:0]  snapshot_q [$];
   edge_report_type       expected_reports [$];

   // The predictor's own copy of the two reported masks.
   logic [WORD_BITS-1:0]  press_latched   = '0;
   logic [WORD_BITS-1:0]  release_latched = '0;

   int                    fail_count  = 0;
   int                    cycle_count = 0;

   // Sender burst and gap bookkeeping, owned by the driver process.
   int                    burst_left = 8;
   int                    gap_left   = 0;

   // Receiver stall pattern, owned by the monitor process.
   stall_mode_type        stall_mode       = STALL_NONE;
   int                    stall_phase_left = 40;
   int                    stall_run        = 0;
   logic                  next_stall;
   edge_report_type       oldest;

   // Snapshot generation.
   logic [WORD_BITS-1:0]  walk;
   int                    flips;
   int                    pick;

   input_edge_event_reporter #(
      .NUM_PORTS (NUM_PORTS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_inputs   (req_raw_inputs),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_press_port   (rsp_press_port),
      .rsp_release_port (rsp_release_port)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Number of the lowest set bit, counted from 1, or 0 for an empty word.
   function automatic port_num_type lowest_port(input logic [WORD_BITS-1:0] fresh);
      lowest_port = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (fresh[i]) begin
            lowest_port = port_num_type'(i + 1);
         end
      end
   endfunction

   // Works out the report for one accepted snapshot and moves both masks on.
   // In each direction the lowest active, not yet reported port is picked and
   // marked; afterwards every port that is no longer active in that direction
   // drops out of the mask, so it can be reported again the next time.
   function automatic edge_report_type take_snapshot(input logic [WORD_BITS-1:0] raw);
      logic [WORD_BITS-1:0] lines;
      logic [WORD_BITS-1:0] pressed;
      logic [WORD_BITS-1:0] released;
      logic [WORD_BITS-1:0] fresh;
      edge_report_type      rep;
      lines    = (NUM_PORTS >= WORD_BITS) ? '1 : ((64'd1 << NUM_PORTS) - 64'd1);
      pressed  = ~raw & lines;
      released = raw & lines;

      fresh            = pressed & ~press_latched;
      rep.press_port   = lowest_port(fresh);
      press_latched    = (press_latched | (fresh & (~fresh + 64'd1))) & pressed;

      fresh            = released & ~release_latched;
      rep.release_port = lowest_port(fresh);
      release_latched  = (release_latched | (fresh & (~fresh + 64'd1))) & released;
      return rep;
   endfunction

   // Stimulus and end of run. The snapshot queue is filled at time zero,
   // before the first clock edge, so the driver never sees it half built.
   initial begin
      // Directed part. The lines are active low, so all ones means that every
      // port is released and all zeros that every port is pressed. Repeated
      // snapshots show that a held input moves on to the next unreported port
      // instead of reporting the same one again.
      snapshot_q = '{
         64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
         64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0000,
         64'hFFFF_FFFF_FFFF_FFFE, 64'hFFFF_FFFF_FFFF_FFFE,
         64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
         64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000,
         64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
         64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555,
         64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA,
         64'h7FFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0001,
         64'hFFFF_FFFF_FFFF_FFFF
      };

      // Random part. Most snapshots follow a walk in which only a few lines
      // change at a time, as real inputs do, so that the masks build up over
      // many beats and held ports are skipped. Now and then a whole byte
      // changes, or the word is replaced outright, at random or by all ones or zeros.
      walk = 64'hFFFF_FFFF_FFFF_FFFF;
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            flips = $urandom_range(0, 3);
            for (int k = 0; k < flips; k++) begin
               walk[$urandom_range(0, WORD_BITS - 1)] ^= 1'b1;
            end
         end else if (pick < 18) begin
            walk[8 * $urandom_range(0, 7) +: 8] = 8'($urandom_range(0, 255));
         end else if (pick < 19) begin
            walk = {$urandom, $urandom};
         end else begin
            walk = ($urandom_range(0, 1) == 0) ? '0 : '1;
         end
         snapshot_q.push_back(walk);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every snapshot must be taken and every report seen before the close.
      while (snapshot_q.size() != 0 || expected_reports.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Driver. The snapshot at the head of the queue stays on the bus until it
   // is accepted; only then is it removed and its report predicted. Between
   // bursts the sender goes quiet for a random gap, and gaps of zero give
   // stretches in which a new beat is offered on every cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_reports.push_back(take_snapshot(req_raw_inputs));
            void'(snapshot_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end

         // A stalled beat is held as it is, with valid left high.
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (snapshot_q.size() != 0) begin
               req_valid      <= 1'b1;
               req_raw_inputs <= snapshot_q[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each accepted response beat is checked field by field against
   // the oldest outstanding report. The same process drives the receiver's
   // stall from a pattern of its own: free-running phases, light and heavy
   // random stalling, and phases with long unbroken stalls.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected response beat: press_port %0d, release_port %0d",
                   rsp_press_port, rsp_release_port);
            fail_count++;
         end else begin
            oldest = expected_reports.pop_front();
            if (rsp_press_port !== oldest.press_port) begin
               $error("press_port mismatch: expected %0d, actual %0d",
                      oldest.press_port, rsp_press_port);
               fail_count++;
            end
            if (rsp_release_port !== oldest.release_port) begin
               $error("release_port mismatch: expected %0d, actual %0d",
                      oldest.release_port, rsp_release_port);
               fail_count++;
            end
         end
      end

      if (stall_phase_left <= 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 3));
         stall_phase_left = $urandom_range(16, 120);
         stall_run        = 0;
      end else begin
         stall_phase_left--;
      end

      case (stall_mode)
         STALL_NONE: begin
            next_stall = 1'b0;
         end
         STALL_LIGHT: begin
            next_stall = ($urandom_range(0, 3) == 0);
         end
         STALL_HEAVY: begin
            next_stall = ($urandom_range(0, 3) != 0);
         end
         default: begin
            if (stall_run > 0) begin
               stall_run--;
               next_stall = 1'b1;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_run  = $urandom_range(1, 10);
               next_stall = 1'b1;
            end else begin
               next_stall = 1'b0;
            end
         end
      endcase
      rsp_stall <= next_stall;
   end

   // Watchdog. Reaching this limit means that the block has hung.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

endmodule

// ----- input_edge_event_reporter.f -----
hdl/iedr_pkg.sv
hdl/iedr_picker.sv
hdl/input_edge_event_reporter.sv
dv/input_edge_event_reporter_tb.sv
